// File: design/efr_pkg.sv
`default_nettype none
package efr_pkg;

  // Word and working widths of the fixed-point datapath
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned EXT_W     = 66;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MIN_LIMIT = 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_C_REAL    = 3'd1,
    REG_C_IMAG    = 3'd2,
    REG_ORIGIN_RE = 3'd3,
    REG_ORIGIN_IM = 3'd4,
    REG_STEP_RE   = 3'd5,
    REG_STEP_IM   = 3'd6,
    REG_ITER_LIM  = 3'd7
  } efr_reg_e;

  // Settings seen by the front end
  typedef struct packed {
    logic                     mandel;
    logic signed [WORD_W-1:0] c_real;
    logic signed [WORD_W-1:0] c_imag;
    logic signed [WORD_W-1:0] origin_re;
    logic signed [WORD_W-1:0] origin_im;
    logic        [STEP_W-1:0] step_re;
    logic        [STEP_W-1:0] step_im;
  } efr_cfg_t;

  // One prepared point waiting for the iteration engine
  typedef struct packed {
    logic signed [WORD_W-1:0] zr;
    logic signed [WORD_W-1:0] zi;
    logic signed [WORD_W-1:0] cr;
    logic signed [WORD_W-1:0] ci;
  } efr_entry_t;

  // Clamp a wide signed value into the 32-bit word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] wmax;
    logic signed [EXT_W-1:0] wmin;
    wmax = $signed({{(EXT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}});
    wmin = $signed({{(EXT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}});
    if (v > wmax) begin
      sat_word = wmax[WORD_W-1:0];
    end else if (v < wmin) begin
      sat_word = wmin[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: design/efr_front.sv
`default_nettype none
module efr_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [COORD_BITS-1:0]  pixel_col_i,
  input  wire logic [COORD_BITS-1:0]  pixel_row_i,
  input  wire efr_pkg::efr_cfg_t      cfg_i,
  output logic                        push_valid_o,
  input  wire logic                   push_ready_i,
  output efr_pkg::efr_entry_t         push_entry_o
);
  import efr_pkg::*;

  localparam int unsigned PRD_W = COORD_BITS + STEP_W;
  localparam int unsigned PT_W  = PRD_W + 2;

  logic                  valid_a_q;
  logic [COORD_BITS-1:0] col_a_q;
  logic [COORD_BITS-1:0] row_a_q;
  logic                  valid_b_q;
  logic [PRD_W-1:0]      prod_re_b_q;
  logic [PRD_W-1:0]      prod_im_b_q;
  logic                  adv_a;
  logic                  adv_b;
  logic signed [PT_W-1:0] sum_re;
  logic signed [PT_W-1:0] sum_im;
  logic signed [WORD_W-1:0] pr;
  logic signed [WORD_W-1:0] pi;

  // Each stage moves on whenever it is empty or the next one has room
  assign adv_b      = !valid_b_q || push_ready_i;
  assign adv_a      = !valid_a_q || adv_b;
  assign in_ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (adv_a) valid_a_q <= in_valid_i;
      if (adv_b) valid_b_q <= valid_a_q;
    end
  end

  // Capture the pixel, then the column and row offsets
  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      col_a_q <= pixel_col_i;
      row_a_q <= pixel_row_i;
    end
    if (adv_b && valid_a_q) begin
      prod_re_b_q <= PRD_W'(col_a_q) * PRD_W'(cfg_i.step_re);
      prod_im_b_q <= PRD_W'(row_a_q) * PRD_W'(cfg_i.step_im);
    end
  end

  // Add the origin, rows counting downward, and saturate
  always_comb begin
    sum_re = $signed({{(PT_W-WORD_W){cfg_i.origin_re[WORD_W-1]}}, cfg_i.origin_re})
           + $signed({2'b00, prod_re_b_q});
    sum_im = $signed({{(PT_W-WORD_W){cfg_i.origin_im[WORD_W-1]}}, cfg_i.origin_im})
           - $signed({2'b00, prod_im_b_q});
    pr = sat_word($signed({{(EXT_W-PT_W){sum_re[PT_W-1]}}, sum_re}));
    pi = sat_word($signed({{(EXT_W-PT_W){sum_im[PT_W-1]}}, sum_im}));
  end

  // Pick starting z and constant by mode
  always_comb begin
    if (cfg_i.mandel) begin
      push_entry_o.zr = '0;
      push_entry_o.zi = '0;
      push_entry_o.cr = pr;
      push_entry_o.ci = pi;
    end else begin
      push_entry_o.zr = pr;
      push_entry_o.zi = pi;
      push_entry_o.cr = cfg_i.c_real;
      push_entry_o.ci = cfg_i.c_imag;
    end
  end

  assign push_valid_o = valid_b_q;

endmodule
`default_nettype wire

// File: design/efr_queue.sv
`default_nettype none
module efr_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  input  wire efr_pkg::efr_entry_t push_entry_i,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i,
  output efr_pkg::efr_entry_t      pop_entry_o
);
  import efr_pkg::*;

  efr_entry_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_entry_i;
  end

endmodule
`default_nettype wire

// File: design/efr_back.sv
`default_nettype none
module efr_back #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned MAX_LIMIT = 1000
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pop_valid_i,
  output logic                               pop_ready_o,
  input  wire efr_pkg::efr_entry_t           pop_entry_i,
  input  wire logic [$clog2(MAX_LIMIT+1)-1:0] limit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [efr_pkg::COUNT_W-1:0]        escape_count_o
);
  import efr_pkg::*;

  localparam int unsigned LIM_W  = $clog2(MAX_LIMIT + 1);
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned SQ_W   = PROD_W - FRAC_BITS;
  localparam logic signed [EXT_W-1:0] FOUR = EXT_W'(4) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ADD  = 3'b100
  } efr_state_e;

  efr_state_e state_q, state_d;
  logic signed [WORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [SQ_W-1:0]   xx_q, yy_q, xy_q;
  logic [LIM_W-1:0]         cnt_q;
  logic                     out_valid_q;
  logic [COUNT_W-1:0]       out_count_q;
  logic signed [PROD_W-1:0] p_xx, p_yy, p_xy;
  logic signed [EXT_W-1:0]  xx_e, yy_e, xy_e;
  logic signed [EXT_W-1:0]  mag;
  logic signed [WORD_W-1:0] nr, ni;
  logic                     escaped;
  logic                     done;
  logic                     out_free;
  logic [LIM_W-1:0]         result;
  logic [LIM_W+COUNT_W-1:0] result_ext;

  // Squaring unit: three products of the current z
  assign p_xx = zr_q * zr_q;
  assign p_yy = zi_q * zi_q;
  assign p_xy = zr_q * zi_q;

  // Update and escape test from the registered products
  always_comb begin
    xx_e = $signed({{(EXT_W-SQ_W){xx_q[SQ_W-1]}}, xx_q});
    yy_e = $signed({{(EXT_W-SQ_W){yy_q[SQ_W-1]}}, yy_q});
    xy_e = $signed({{(EXT_W-SQ_W){xy_q[SQ_W-1]}}, xy_q});
    mag  = xx_e + yy_e;
    nr   = sat_word(xx_e - yy_e + EXT_W'(cr_q));
    ni   = sat_word((xy_e <<< 1) + EXT_W'(ci_q));
    escaped = (cnt_q != '0) && (mag > FOUR);
    done    = escaped || (cnt_q == limit_i);
    result  = escaped ? (cnt_q - LIM_W'(1)) : cnt_q;
    result_ext = {{COUNT_W{1'b0}}, result};
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == S_IDLE);

  // Sequence: load, multiply, update or finish
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (pop_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD: begin
        if (!done) begin
          state_d = S_MUL;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ADD && done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_valid_i) begin
      zr_q  <= pop_entry_i.zr;
      zi_q  <= pop_entry_i.zi;
      cr_q  <= pop_entry_i.cr;
      ci_q  <= pop_entry_i.ci;
      cnt_q <= '0;
    end
    if (state_q == S_MUL) begin
      xx_q <= p_xx[PROD_W-1:FRAC_BITS];
      yy_q <= p_yy[PROD_W-1:FRAC_BITS];
      xy_q <= p_xy[PROD_W-1:FRAC_BITS];
    end
    if (state_q == S_ADD && !done) begin
      zr_q  <= nr;
      zi_q  <= ni;
      cnt_q <= cnt_q + LIM_W'(1);
    end
    if (state_q == S_ADD && done && out_free) begin
      out_count_q <= result_ext[COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_count_q;

endmodule
`default_nettype wire

// File: design/escape_time_fractal.sv
`default_nettype none
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  pixel_col_i, pixel_row_i
// out      output     out_valid_o / out_ready_i escape_count_o
// cfg      input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// The iteration engine runs each pixel until it escapes or reaches the limit L; the
// squaring unit forms three registered 32x32 products of z (S_MUL), then adds and
// saturates (S_ADD) once per iteration.
// The registered point setup and a two-entry queue overlap the next pixel with the engine.
// Reset clears handshake and control state and loads the register defaults.
// The input side keeps accepting while a result waits for out_ready_i, until setup, queue and engine are full.
module escape_time_fractal #(
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned MAX_LIMIT  = 1000,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [COORD_BITS-1:0]           pixel_col_i,
  input  wire logic [COORD_BITS-1:0]           pixel_row_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [efr_pkg::COUNT_W-1:0]          escape_count_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [efr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [efr_pkg::WORD_W-1:0]      cfg_wdata_i
);
  import efr_pkg::*;

  localparam int unsigned LIM_W = $clog2(MAX_LIMIT + 1);

  efr_cfg_t           cfg_q;
  logic [COUNT_W-1:0] iter_lim_q;
  logic [LIM_W-1:0]   limit;
  logic               push_valid;
  logic               push_ready;
  efr_entry_t         push_entry;
  logic               pop_valid;
  logic               pop_ready;
  efr_entry_t         pop_entry;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mandel    <= 1'b0;
      cfg_q.c_real    <= -32'sd201863463;
      cfg_q.c_imag    <= 32'sd31406949;
      cfg_q.origin_re <= -32'sd536870912;
      cfg_q.origin_im <= 32'sd536870912;
      cfg_q.step_re   <= 31'd3579139;
      cfg_q.step_im   <= 31'd3579139;
      iter_lim_q      <= 10'd1000;
    end else if (cfg_we_i) begin
      unique case (efr_reg_e'(cfg_idx_i))
        REG_MODE:      cfg_q.mandel    <= cfg_wdata_i[0];
        REG_C_REAL:    cfg_q.c_real    <= $signed(cfg_wdata_i);
        REG_C_IMAG:    cfg_q.c_imag    <= $signed(cfg_wdata_i);
        REG_ORIGIN_RE: cfg_q.origin_re <= $signed(cfg_wdata_i);
        REG_ORIGIN_IM: cfg_q.origin_im <= $signed(cfg_wdata_i);
        REG_STEP_RE:   cfg_q.step_re   <= cfg_wdata_i[STEP_W-1:0];
        REG_STEP_IM:   cfg_q.step_im   <= cfg_wdata_i[STEP_W-1:0];
        REG_ITER_LIM:  iter_lim_q      <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the limit into its legal span
  always_comb begin
    if (iter_lim_q < COUNT_W'(MIN_LIMIT)) begin
      limit = LIM_W'(MIN_LIMIT);
    end else if (32'(iter_lim_q) > 32'(MAX_LIMIT)) begin
      limit = LIM_W'(MAX_LIMIT);
    end else begin
      limit = LIM_W'(iter_lim_q);
    end
  end

  efr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  efr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  efr_back #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_LIMIT(MAX_LIMIT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .limit_i        (limit),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .escape_count_o (escape_count_o)
  );

endmodule
`default_nettype wire

// File: design/efr_checker.sv
`default_nettype none
module efr_checker #(
  parameter int unsigned MAX_LIMIT = 1000
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [efr_pkg::COUNT_W-1:0] escape_count_o
);
  import efr_pkg::*;

  logic [3:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Track pixels taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 4'd1;
    end
  end

  // A stalled result holds its count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(escape_count_o))
    else $error("result dropped or changed while stalled");

  // No result without a pixel behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without an outstanding pixel");

  // Pipeline, queue, engine and output hold at most six pixels
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd6)
    else $error("more pixels in flight than the design can hold");

  // Count never exceeds the limit ceiling
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(escape_count_o) <= MAX_LIMIT)
    else $error("escape count above the limit ceiling");

  // Leaving reset shows no result
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result visible straight after reset");

endmodule

bind escape_time_fractal efr_checker #(
  .MAX_LIMIT(MAX_LIMIT)
) u_efr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .escape_count_o (escape_count_o)
);
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
  import efr_pkg::*;

  localparam int unsigned FRAC        = 28;
  localparam int unsigned LIMIT_MAX   = 1000;
  localparam int unsigned COORD       = 12;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_AT     = 32;
  localparam int unsigned HOLD_LEN    = 500;
  localparam int unsigned RAND_ITEMS  = 550;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam longint      WORD_HI     = 64'sd2147483647;
  localparam longint      WORD_LO     = -64'sd2147483648;

  typedef struct packed {
    logic [COORD-1:0] col;
    logic [COORD-1:0] row;
  } pixel_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [COORD-1:0]     pixel_col_i    = '0;
  logic [COORD-1:0]     pixel_row_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [COUNT_W-1:0]   escape_count_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [WORD_W-1:0]    cfg_wdata_i    = '0;

  // Mirror of the register file
  logic                     sh_mandel;
  logic signed [WORD_W-1:0] sh_c_re;
  logic signed [WORD_W-1:0] sh_c_im;
  logic signed [WORD_W-1:0] sh_origin_re;
  logic signed [WORD_W-1:0] sh_origin_im;
  logic        [STEP_W-1:0] sh_step_re;
  logic        [STEP_W-1:0] sh_step_im;
  logic       [COUNT_W-1:0] sh_limit;

  pixel_t             pixel_q[$];
  logic [COUNT_W-1:0] escape_q[$];
  pixel_t             next_px;
  logic [COUNT_W-1:0] want;
  int unsigned        gap_left;
  int unsigned        stall_left;
  int unsigned        idle_n;
  int unsigned        hold_left;
  bit                 hold_done;
  bit                 no_idle = 1'b0;
  int unsigned        n_sent;
  int unsigned        n_cycles = 0;
  int unsigned        n_err = 0;
  int unsigned        rand_items = 0;

  escape_time_fractal #(
    .FRAC_BITS (FRAC),
    .MAX_LIMIT (LIMIT_MAX),
    .COORD_BITS(COORD)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .escape_count_o(escape_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clamp into the signed 32-bit word
  function automatic longint clamp_word(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Fixed-point product, floored towards minus infinity
  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  // Iteration count at which the orbit of this pixel leaves the radius-2 disc
  function automatic logic [COUNT_W-1:0] escape_of(input logic [COORD-1:0] col,
                                                  input logic [COORD-1:0] row);
    longint      pr, pi, zr, zi, cr, ci, xx, yy, xy, four;
    int unsigned lim, k;
    four = 64'sd4 <<< FRAC;
    pr = clamp_word(longint'(sh_origin_re) + longint'(col) * longint'(sh_step_re));
    pi = clamp_word(longint'(sh_origin_im) - longint'(row) * longint'(sh_step_im));
    lim = sh_limit;
    if (lim < MIN_LIMIT) lim = MIN_LIMIT;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    if (sh_mandel) begin
      zr = 0;
      zi = 0;
      cr = pr;
      ci = pi;
    end else begin
      zr = pr;
      zi = pi;
      cr = longint'(sh_c_re);
      ci = longint'(sh_c_im);
    end
    xx = fmul(zr, zr);
    yy = fmul(zi, zi);
    for (k = 0; k < lim; k++) begin
      xy = fmul(zr, zi);
      zr = clamp_word(xx - yy + cr);
      zi = clamp_word(2 * xy + ci);
      xx = fmul(zr, zr);
      yy = fmul(zi, zi);
      if (xx + yy > four) break;
    end
    return k[COUNT_W-1:0];
  endfunction

  function automatic int unsigned draw_idle();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", n_cycles, msg);
    n_err++;
  endtask

  task automatic add_pixel(input int unsigned col, input int unsigned row);
    pixel_q.push_back(pixel_t'({col[COORD-1:0], row[COORD-1:0]}));
  endtask

  // Write one register and update the mirror
  task automatic write_reg(input efr_reg_e idx, input logic [WORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_MODE:      sh_mandel    = val[0];
      REG_C_REAL:    sh_c_re      = val;
      REG_C_IMAG:    sh_c_im      = val;
      REG_ORIGIN_RE: sh_origin_re = val;
      REG_ORIGIN_IM: sh_origin_im = val;
      REG_STEP_RE:   sh_step_re   = val[STEP_W-1:0];
      REG_STEP_IM:   sh_step_im   = val[STEP_W-1:0];
      REG_ITER_LIM:  sh_limit     = val[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] mode, input logic [31:0] cr,
                         input logic [31:0] ci, input logic [31:0] ore,
                         input logic [31:0] oim, input logic [31:0] sre,
                         input logic [31:0] sim, input logic [31:0] lim);
    write_reg(REG_MODE, mode);
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_ORIGIN_RE, ore);
    write_reg(REG_ORIGIN_IM, oim);
    write_reg(REG_STEP_RE, sre);
    write_reg(REG_STEP_IM, sim);
    write_reg(REG_ITER_LIM, lim);
    @(negedge clk_i);
  endtask

  // Wait until every pixel is through and every count is back
  task automatic drain();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || escape_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One window of the plane, or pure noise, with most pixels drawn inside the window
  task automatic random_phase(input bit fixed_view);
    int unsigned kind, span, extent, lim, lim10, eff, n_items, i;
    logic [31:0] mode_w, cr_w, ci_w, ore_w, oim_w, sre_w, sim_w, lim_w;
    longint      ore, oim, cr, ci;
    kind = fixed_view ? 1 : $urandom_range(0, 9);
    span = 4096;
    if (kind == 0) begin
      mode_w = $urandom();
      cr_w   = $urandom();
      ci_w   = $urandom();
      ore_w  = $urandom();
      oim_w  = $urandom();
      sre_w  = $urandom();
      sim_w  = $urandom();
      lim_w  = $urandom();
    end else begin
      span   = 1 << $urandom_range(3, 12);
      extent = $urandom_range(1, 4);
      ore    = longint'($urandom_range(0, 3 << 28)) - (64'sd5 <<< 27);
      oim    = longint'($urandom_range(1 << 27, 1 << 29));
      cr     = longint'($urandom_range(0, 3 << 27)) - (64'sd1 <<< 28);
      ci     = longint'($urandom_range(0, 3 << 27)) - (64'sd3 <<< 26);
      mode_w = ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1));
      cr_w   = cr[31:0];
      ci_w   = ci[31:0];
      ore_w  = ore[31:0];
      oim_w  = oim[31:0];
      sre_w  = 32'((longint'(extent) <<< FRAC) / span) | {$urandom_range(0, 1) == 1, 31'b0};
      sim_w  = 32'((longint'(extent) <<< FRAC) / span) | {$urandom_range(0, 1) == 1, 31'b0};
      case ($urandom_range(0, 9))
        0:       lim = $urandom_range(0, 9);
        1:       lim = ($urandom_range(0, 1) == 1) ? 1000 : 1023;
        default: lim = $urandom_range(10, 64);
      endcase
      if (fixed_view) lim = 16;
      lim_w = ($urandom() & 32'hFFFF_FC00) | lim;
    end
    lim10 = lim_w[COUNT_W-1:0];
    eff = (lim10 < MIN_LIMIT) ? MIN_LIMIT : ((lim10 > LIMIT_MAX) ? LIMIT_MAX : lim10);
    n_items = (eff >= 500) ? 6 : 40;
    no_idle = !fixed_view && ($urandom_range(0, 3) == 0);
    set_all(mode_w, cr_w, ci_w, ore_w, oim_w, sre_w, sim_w, lim_w);
    for (i = 0; i < n_items; i++) begin
      if (kind != 0 && $urandom_range(0, 7) != 0) begin
        add_pixel($urandom_range(0, span - 1), $urandom_range(0, span - 1));
      end else begin
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
    rand_items += n_items;
    drain();
  endtask

  // Driver: present queued pixels, predict each count on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
      n_sent     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        escape_q.push_back(escape_of(pixel_col_i, pixel_row_i));
        n_sent <= n_sent + 1;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offered pixel
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        next_px     = pixel_q.pop_front();
        pixel_col_i <= next_px.col;
        pixel_row_i <= next_px.row;
        in_valid_i  <= 1'b1;
        gap_left    <= draw_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Hold off the output side once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result transfer with the oldest predicted count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (escape_q.size() == 0) begin
          report_mismatch($sformatf("unexpected count %0d", escape_count_o));
        end else begin
          want = escape_q.pop_front();
          if (escape_count_o !== want) begin
            report_mismatch($sformatf("escape_count got %0d want %0d", escape_count_o, want));
          end
        end
        idle_n      = draw_idle();
        stall_left  <= idle_n;
        out_ready_i <= (idle_n == 0) && (hold_left == 0);
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (hold_left == 0);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sh_mandel    = 1'b0;
    sh_c_re      = -32'sd201863463;
    sh_c_im      = 32'sd31406949;
    sh_origin_re = -32'sd536870912;
    sh_origin_im = 32'sd536870912;
    sh_step_re   = 31'd3579139;
    sh_step_im   = 31'd3579139;
    sh_limit     = 10'd1000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: corners other than (0,0) saturate the point, centre stays bounded
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(150, 150);
    add_pixel(100, 180);
    drain();

    // Word extremes, masked upper bits, limit below the minimum
    set_all(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(2048, 1);
    add_pixel(1, 2048);
    drain();

    // Origin never leaves zero: limit above the maximum is reached
    set_all(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_03FF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    drain();

    // Mandelbrot view at the smallest limit
    set_all(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, -32'sd536870912,
            32'd335544320, 32'd196608, 32'd196608, 32'd10);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(2047, 2047);
    add_pixel(3000, 1000);
    add_pixel(1024, 3072);
    add_pixel(2500, 2000);
    drain();

    // Julia view at the largest limit
    set_all(32'h0000_0000, 32'd76504555, 32'd2684355, -32'sd402653184,
            32'd268435456, 32'd196608, 32'd196608, 32'd1000);
    add_pixel(2048, 1365);
    add_pixel(1000, 2000);
    add_pixel(4095, 4095);
    add_pixel(2731, 1500);
    drain();

    // Random windows and noise
    random_phase(1'b1);
    while (rand_items < RAND_ITEMS) random_phase(1'b0);

    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
